// ===== hw/rtl/rcwb_pkg.sv =====
package rcwb_pkg;

    // fixed field widths
    localparam int POS_W      = 8;
    localparam int PIX_W      = 8;
    localparam int COEF_W     = 16;
    localparam int TAP_IDX_W  = 6;
    localparam int ACTION_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;
    localparam int KSIZE_W    = 3;
    localparam int RGB_W      = 3 * PIX_W;

    localparam int PIX_MAX = 255;

    // action codes
    localparam logic [ACTION_W-1:0] ACT_WRITE_COEF  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_WRITE_PIXEL = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_READ        = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_SIZE  = 2'd2;

    // reset values of the configuration registers
    localparam logic [CFG_DATA_W-1:0] IMAGE_WIDTH_RST  = 9'd256;
    localparam logic [CFG_DATA_W-1:0] IMAGE_HEIGHT_RST = 9'd256;
    localparam logic [KSIZE_W-1:0]    KERNEL_SIZE_RST  = 3'd3;

    // controller to datapath commands
    typedef struct packed {
        logic wr_coef;
        logic wr_pixel;
        logic capture;
        logic mod_step;
        logic back_step;
        logic issue;
        logic row_end;
        logic finish;
    } rcwb_cmd_t;

endpackage

// ===== hw/rtl/rcwb_ram.sv =====
module rcwb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// ===== hw/rtl/rcwb_ctrl.sv =====
module rcwb_ctrl #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int MAX_KERNEL = 7
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [rcwb_pkg::ACTION_W-1:0]   action,
    input  logic [rcwb_pkg::POS_W-1:0]      pos_x,
    input  logic [rcwb_pkg::POS_W-1:0]      pos_y,
    input  logic [rcwb_pkg::TAP_IDX_W-1:0]  tap_index,
    input  logic [$clog2(MAX_KERNEL+1)-1:0] radius,
    output rcwb_pkg::rcwb_cmd_t             cmd,
    output logic                            busy
);
    import rcwb_pkg::*;

    localparam int KW   = $clog2(MAX_KERNEL + 1);
    localparam int CW   = (KW > 3) ? KW : 3;
    localparam int TAPS = MAX_KERNEL * MAX_KERNEL;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MOD   = 3'd1;
    localparam logic [2:0] ST_BACK  = 3'd2;
    localparam logic [2:0] ST_WALK  = 3'd3;
    localparam logic [2:0] ST_DRAIN = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [KW-1:0] col_reg, col_next;
    logic [KW-1:0] row_reg, row_next;
    logic [KW-1:0] side;
    logic          idle_take;
    logic          row_last;
    logic          col_last;

    assign side      = KW'({radius, 1'b1});
    assign idle_take = (state_reg == ST_IDLE) && start;
    assign col_last  = (col_reg == side - KW'(1));
    assign row_last  = (row_reg == side - KW'(1));

    always_comb
    begin
        cmd          = '0;
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        col_next     = col_reg;
        row_next     = row_reg;

        cmd.wr_coef  = idle_take && (action == ACT_WRITE_COEF) &&
                       ({26'd0, tap_index} < TAPS);
        cmd.wr_pixel = idle_take && (action == ACT_WRITE_PIXEL) &&
                       ({24'd0, pos_x} < MAX_WIDTH) && ({24'd0, pos_y} < MAX_HEIGHT);

        case (state_reg)
            ST_IDLE:
            begin
                if (idle_take && (action == ACT_READ))
                begin
                    cmd.capture = 1'b1;
                    cnt_next    = '0;
                    state_next  = ST_MOD;
                end
            end
            ST_MOD:
            begin
                cmd.mod_step = 1'b1;
                cnt_next     = cnt_reg + CW'(1);
                if (cnt_reg == CW'(POS_W - 1))
                begin
                    cnt_next = '0;
                    col_next = '0;
                    row_next = '0;
                    if (radius == '0)
                    begin
                        state_next = ST_WALK;
                    end
                    else
                    begin
                        state_next = ST_BACK;
                    end
                end
            end
            ST_BACK:
            begin
                cmd.back_step = 1'b1;
                cnt_next      = cnt_reg + CW'(1);
                if (cnt_reg == CW'(radius) - CW'(1))
                begin
                    cnt_next   = '0;
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                cmd.issue   = 1'b1;
                cmd.row_end = col_last;
                if (col_last)
                begin
                    col_next = '0;
                    row_next = row_reg + KW'(1);
                    if (row_last)
                    begin
                        cnt_next   = '0;
                        state_next = ST_DRAIN;
                    end
                end
                else
                begin
                    col_next = col_reg + KW'(1);
                end
            end
            ST_DRAIN:
            begin
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                cmd.finish = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            col_reg   <= '0;
            row_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);
endmodule

// ===== hw/rtl/rcwb_datapath.sv =====
module rcwb_datapath #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int MAX_KERNEL = 7
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  rcwb_pkg::rcwb_cmd_t                 cmd,
    input  logic [rcwb_pkg::POS_W-1:0]          pos_x,
    input  logic [rcwb_pkg::POS_W-1:0]          pos_y,
    input  logic [rcwb_pkg::PIX_W-1:0]          red_in,
    input  logic [rcwb_pkg::PIX_W-1:0]          green_in,
    input  logic [rcwb_pkg::PIX_W-1:0]          blue_in,
    input  logic [rcwb_pkg::TAP_IDX_W-1:0]      tap_index,
    input  logic signed [rcwb_pkg::COEF_W-1:0]  tap_weight,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]      width_use,
    input  logic [$clog2(MAX_HEIGHT+1)-1:0]     height_use,
    output logic                                result_valid,
    output logic [rcwb_pkg::PIX_W-1:0]          red_out,
    output logic [rcwb_pkg::PIX_W-1:0]          green_out,
    output logic [rcwb_pkg::PIX_W-1:0]          blue_out
);
    import rcwb_pkg::*;

    localparam int WW     = $clog2(MAX_WIDTH + 1);
    localparam int HW     = $clog2(MAX_HEIGHT + 1);
    localparam int XRW    = WW + 1;
    localparam int YRW    = HW + 1;
    localparam int XW     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int YW     = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int PDEPTH = MAX_HEIGHT << XW;
    localparam int PAW    = (PDEPTH > 1) ? $clog2(PDEPTH) : 1;
    localparam int TAPS   = MAX_KERNEL * MAX_KERNEL;
    localparam int TW     = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int PROD_W = COEF_W + PIX_W + 1;
    localparam int AW     = PROD_W + ((TAPS > 1) ? $clog2(TAPS) : 0) + 1;

    // coordinate walk
    logic [POS_W-1:0] shx_reg, shy_reg;
    logic [XRW-1:0]   xx_reg, xx_next, xs_reg;
    logic [YRW-1:0]   yy_reg, yy_next;
    logic [XRW-1:0]   xt;
    logic [YRW-1:0]   yt;
    logic [XRW-1:0]   w_ext;
    logic [YRW-1:0]   h_ext;
    logic [TW-1:0]    tap_reg;

    // memories
    logic [PAW-1:0]    pix_waddr, pix_raddr;
    logic [RGB_W-1:0]  pix_rdata;
    logic [COEF_W-1:0] coef_rdata;

    // multiply-accumulate pipeline
    logic                     issue_d1_reg, issue_d2_reg;
    logic signed [PROD_W-1:0] prod_r_reg, prod_g_reg, prod_b_reg;
    logic signed [AW-1:0]     acc_r_reg, acc_g_reg, acc_b_reg;
    logic                     valid_reg;
    logic [PIX_W-1:0]         red_reg, green_reg, blue_reg;

    function automatic logic [PIX_W-1:0] finish_chan(input logic signed [AW-1:0] acc);
        logic signed [AW-1:0] q;
        logic [PIX_W-1:0]     res;
        q = acc >>> 8;
        if (acc <= 0)
        begin
            res = '0;
        end
        else if (q > AW'(PIX_MAX))
        begin
            res = PIX_W'(PIX_MAX);
        end
        else
        begin
            res = q[PIX_W-1:0];
        end
        return res;
    endfunction

    assign w_ext = XRW'(width_use);
    assign h_ext = YRW'(height_use);

    // restoring remainder step, then wrap-around decrement and increment
    always_comb
    begin
        xt      = {xx_reg[XRW-2:0], shx_reg[POS_W-1]};
        yt      = {yy_reg[YRW-2:0], shy_reg[POS_W-1]};
        xx_next = xx_reg;
        yy_next = yy_reg;
        if (cmd.mod_step)
        begin
            xx_next = (xt >= w_ext) ? xt - w_ext : xt;
            yy_next = (yt >= h_ext) ? yt - h_ext : yt;
        end
        else if (cmd.back_step)
        begin
            xx_next = (xx_reg == '0) ? w_ext - XRW'(1) : xx_reg - XRW'(1);
            yy_next = (yy_reg == '0) ? h_ext - YRW'(1) : yy_reg - YRW'(1);
        end
        else if (cmd.issue)
        begin
            if (cmd.row_end)
            begin
                xx_next = xs_reg;
                yy_next = (yy_reg == h_ext - YRW'(1)) ? '0 : yy_reg + YRW'(1);
            end
            else
            begin
                xx_next = (xx_reg == w_ext - XRW'(1)) ? '0 : xx_reg + XRW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            shx_reg <= pos_x;
            shy_reg <= pos_y;
            xx_reg  <= '0;
            xs_reg  <= '0;
            yy_reg  <= '0;
            tap_reg <= '0;
        end
        else
        begin
            if (cmd.mod_step)
            begin
                shx_reg <= shx_reg << 1;
                shy_reg <= shy_reg << 1;
            end
            if (cmd.mod_step || cmd.back_step)
            begin
                xs_reg <= xx_next;
            end
            if (cmd.issue)
            begin
                tap_reg <= tap_reg + TW'(1);
            end
            xx_reg <= xx_next;
            yy_reg <= yy_next;
        end
    end

    assign pix_waddr = PAW'({YW'(pos_y), XW'(pos_x)});
    assign pix_raddr = PAW'({yy_reg[YW-1:0], xx_reg[XW-1:0]});

    rcwb_ram #(
        .WIDTH(RGB_W),
        .DEPTH(PDEPTH)
    ) u_pixel_ram (
        .clk  (clk),
        .we   (cmd.wr_pixel),
        .waddr(pix_waddr),
        .wdata({red_in, green_in, blue_in}),
        .raddr(pix_raddr),
        .rdata(pix_rdata)
    );

    rcwb_ram #(
        .WIDTH(COEF_W),
        .DEPTH(TAPS)
    ) u_coef_ram (
        .clk  (clk),
        .we   (cmd.wr_coef),
        .waddr(TW'(tap_index)),
        .wdata(tap_weight),
        .raddr(tap_reg),
        .rdata(coef_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_d1_reg <= 1'b0;
            issue_d2_reg <= 1'b0;
            valid_reg    <= 1'b0;
        end
        else
        begin
            issue_d1_reg <= cmd.issue;
            issue_d2_reg <= issue_d1_reg;
            valid_reg    <= cmd.finish;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_r_reg <= PROD_W'($signed(coef_rdata)) *
                      PROD_W'($signed({1'b0, pix_rdata[3*PIX_W-1:2*PIX_W]}));
        prod_g_reg <= PROD_W'($signed(coef_rdata)) *
                      PROD_W'($signed({1'b0, pix_rdata[2*PIX_W-1:PIX_W]}));
        prod_b_reg <= PROD_W'($signed(coef_rdata)) *
                      PROD_W'($signed({1'b0, pix_rdata[PIX_W-1:0]}));
        if (cmd.capture)
        begin
            acc_r_reg <= '0;
            acc_g_reg <= '0;
            acc_b_reg <= '0;
        end
        else if (issue_d2_reg)
        begin
            acc_r_reg <= acc_r_reg + AW'(prod_r_reg);
            acc_g_reg <= acc_g_reg + AW'(prod_g_reg);
            acc_b_reg <= acc_b_reg + AW'(prod_b_reg);
        end
        if (cmd.finish)
        begin
            red_reg   <= finish_chan(acc_r_reg);
            green_reg <= finish_chan(acc_g_reg);
            blue_reg  <= finish_chan(acc_b_reg);
        end
    end

    assign result_valid = valid_reg;
    assign red_out      = red_reg;
    assign green_out    = green_reg;
    assign blue_out     = blue_reg;
endmodule

// ===== hw/rtl/rgb_convolution_wrap_border_unit.sv =====
// RGB convolution with wrap-around borders. A command is taken on a clock edge
// where start is high and busy is low. Coefficient and pixel writes take effect at
// that edge and leave busy low. A read keeps busy high through a bit-serial modulo
// of the centre coordinate, a step back by the kernel radius r to the window corner,
// one cycle per tap for the s*s taps (s = 2r+1) through the single read port of the
// pixel memory, and the multiply-accumulate drain and clamping. result_valid pulses
// for exactly one cycle, the cycle in which busy falls, and the receiver cannot
// stall it: capture red_out, green_out and blue_out in that cycle. No clearing
// pass after reset; stored pixels and coefficients must be written before use.
module rgb_convolution_wrap_border_unit #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int MAX_KERNEL = 7
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // command channel
    input  logic                                start,
    output logic                                busy,
    input  logic [rcwb_pkg::ACTION_W-1:0]       action,
    input  logic [rcwb_pkg::POS_W-1:0]          pos_x,
    input  logic [rcwb_pkg::POS_W-1:0]          pos_y,
    input  logic [rcwb_pkg::PIX_W-1:0]          red_in,
    input  logic [rcwb_pkg::PIX_W-1:0]          green_in,
    input  logic [rcwb_pkg::PIX_W-1:0]          blue_in,
    input  logic [rcwb_pkg::TAP_IDX_W-1:0]      tap_index,
    input  logic signed [rcwb_pkg::COEF_W-1:0]  tap_weight,
    // result strobe and data
    output logic                                result_valid,
    output logic [rcwb_pkg::PIX_W-1:0]          red_out,
    output logic [rcwb_pkg::PIX_W-1:0]          green_out,
    output logic [rcwb_pkg::PIX_W-1:0]          blue_out,
    // configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rcwb_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rcwb_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import rcwb_pkg::*;

    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int HW   = $clog2(MAX_HEIGHT + 1);
    localparam int KW   = $clog2(MAX_KERNEL + 1);
    localparam int RMAX = MAX_KERNEL / 2;

    // configuration registers
    logic [CFG_DATA_W-1:0] image_width_reg;
    logic [CFG_DATA_W-1:0] image_height_reg;
    logic [KSIZE_W-1:0]    kernel_size_reg;

    // sizes in use after clamping
    logic [WW-1:0] width_use;
    logic [HW-1:0] height_use;
    logic [KW-1:0] radius;

    rcwb_cmd_t cmd;

    // every configuration transfer is taken at once
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= IMAGE_WIDTH_RST;
            image_height_reg <= IMAGE_HEIGHT_RST;
            kernel_size_reg  <= KERNEL_SIZE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data;
                REG_IMAGE_HEIGHT: image_height_reg <= cfg_data;
                REG_KERNEL_SIZE:  kernel_size_reg  <= cfg_data[KSIZE_W-1:0];
                default:          ;
            endcase
        end
    end

    // zero acts as one, anything above the store size acts as the store size
    always_comb
    begin
        if (image_width_reg == '0)
        begin
            width_use = WW'(1);
        end
        else if ({23'd0, image_width_reg} > MAX_WIDTH)
        begin
            width_use = WW'(MAX_WIDTH);
        end
        else
        begin
            width_use = WW'(image_width_reg);
        end

        if (image_height_reg == '0)
        begin
            height_use = HW'(1);
        end
        else if ({23'd0, image_height_reg} > MAX_HEIGHT)
        begin
            height_use = HW'(MAX_HEIGHT);
        end
        else
        begin
            height_use = HW'(image_height_reg);
        end

        // even sizes round up to the next odd side, radius capped by the tap store
        if ({30'd0, kernel_size_reg[KSIZE_W-1:1]} > RMAX)
        begin
            radius = KW'(RMAX);
        end
        else
        begin
            radius = KW'(kernel_size_reg[KSIZE_W-1:1]);
        end
    end

    rcwb_ctrl #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT),
        .MAX_KERNEL(MAX_KERNEL)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .action   (action),
        .pos_x    (pos_x),
        .pos_y    (pos_y),
        .tap_index(tap_index),
        .radius   (radius),
        .cmd      (cmd),
        .busy     (busy)
    );

    rcwb_datapath #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT),
        .MAX_KERNEL(MAX_KERNEL)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .red_in      (red_in),
        .green_in    (green_in),
        .blue_in     (blue_in),
        .tap_index   (tap_index),
        .tap_weight  (tap_weight),
        .width_use   (width_use),
        .height_use  (height_use),
        .result_valid(result_valid),
        .red_out     (red_out),
        .green_out   (green_out),
        .blue_out    (blue_out)
    );
endmodule

// ===== hw/rtl/rcwb_checker.sv =====
module rcwb_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              start,
    input logic                              busy,
    input logic [rcwb_pkg::ACTION_W-1:0]     action,
    input logic                              result_valid
);
    import rcwb_pkg::*;

    // a read transfer occupies the block
    a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && action == ACT_READ) |=> busy)
        else $error("read transfer did not raise busy");

    // writes and unused codes do not raise busy
    a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && action != ACT_READ) |=> !busy)
        else $error("non-read transfer raised busy");

    // a result only appears as busy drops
    a_result_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (!busy && $past(busy)))
        else $error("result strobe outside end of read");

    // every read ends with a result
    a_end_has_result: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> result_valid)
        else $error("read ended without result");
endmodule

bind rgb_convolution_wrap_border_unit rcwb_checker u_rcwb_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .action      (action),
    .result_valid(result_valid)
);
